### src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold
`define BFAC_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("bloom filter check failed");

// ante implies cons in the same cycle
`define BFAC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bloom filter check failed");

// ante implies cons in the next cycle
`define BFAC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bloom filter check failed");

`endif

### src/bfac_pkg.sv
// Shared types and constants of the bloom filter block
`timescale 1ns / 1ps
package bfac_pkg;
    localparam int HASH_W     = 32;
    localparam int HASH_FIELDS = 4;
    localparam int HCNT_W     = 3;
    localparam int STEP_CNT_W = 5;
    localparam int VB_W       = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASHES_IN_USE = 2'd1;

    localparam logic [7:0] BIT_MSB = 8'h80;

    typedef struct packed {
        logic              start;
        logic              is_check;
        logic [HCNT_W-1:0] count;
    } bfac_cmd_t;

    typedef struct packed {
        logic clearing;
        logic done;
        logic present;
    } bfac_sts_t;
endpackage

### src/bfac_mod_lane.sv
// One lane: bit-serial remainder of a 32-bit hash by the vector length
`timescale 1ns / 1ps
module bfac_mod_lane import bfac_pkg::*; #(
    parameter int LEN_W = 17,
    parameter int IDX_W = 16
) (
    input  logic              aclk,
    input  logic              load,
    input  logic              step,
    input  logic [LEN_W-1:0]  len,
    input  logic [HASH_W-1:0] hash,
    output logic [IDX_W-1:0]  rem
);
    logic [HASH_W-1:0] sh_reg, sh_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W:0]    trial;

    always_comb begin
        trial    = {rem_reg, sh_reg[HASH_W-1]};
        sh_next  = sh_reg;
        rem_next = rem_reg;
        if (load) begin
            sh_next  = hash;
            rem_next = '0;
        end else if (step) begin
            sh_next = {sh_reg[HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, len}) begin
                rem_next = LEN_W'(trial - {1'b0, len});
            end else begin
                rem_next = LEN_W'(trial);
            end
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign rem = IDX_W'(rem_reg);
endmodule

### src/bfac_merge.sv
// Filter memory, clearing pass and the walk that merges lane indices
`timescale 1ns / 1ps
module bfac_merge import bfac_pkg::*; #(
    parameter int NUM_LANES = 4,
    parameter int IDX_W     = 16,
    parameter int DEPTH     = 8192,
    parameter int ADDR_W    = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  bfac_cmd_t        cmd,
    input  logic [IDX_W-1:0] idx [NUM_LANES],
    output bfac_sts_t        sts
);
    localparam logic [1:0] M_CLR = 2'd0, M_IDLE = 2'd1, M_RD = 2'd2, M_UPD = 2'd3;

    logic [1:0]        st_reg, st_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [HCNT_W-1:0] sel_reg, sel_next, cnt_reg, cnt_next;
    logic              chk_reg, chk_next, pres_reg, pres_next, done_reg, done_next;
    logic [IDX_W-1:0]  idx_cur;
    logic [7:0]        mask, rd_data, wdata;
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic [7:0]        mem [DEPTH];

    always_comb begin
        idx_cur = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (sel_reg == HCNT_W'(i)) idx_cur = idx[i];
        end
        mask  = BIT_MSB >> idx_cur[2:0];
        addr  = (st_reg == M_CLR) ? clr_reg : ADDR_W'(idx_cur >> 3);
        we    = (st_reg == M_CLR) || (st_reg == M_UPD && !chk_reg);
        wdata = (st_reg == M_CLR) ? 8'h00 : (rd_data | mask);
    end

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rd_data <= mem[addr];
    end

    always_comb begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        sel_next  = sel_reg;
        cnt_next  = cnt_reg;
        chk_next  = chk_reg;
        pres_next = pres_reg;
        done_next = 1'b0;
        unique case (st_reg)
            M_CLR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) st_next = M_IDLE;
            end
            M_IDLE: begin
                if (cmd.start) begin
                    pres_next = 1'b1;
                    sel_next  = '0;
                    cnt_next  = cmd.count;
                    chk_next  = cmd.is_check;
                    if (cmd.count == '0) done_next = 1'b1;
                    else st_next = M_RD;
                end
            end
            M_RD: st_next = M_UPD;
            M_UPD: begin
                priority if (chk_reg && (rd_data & mask) == 8'h00) begin
                    pres_next = 1'b0;
                    done_next = 1'b1;
                    st_next   = M_IDLE;
                end else if (sel_reg + 1'b1 == cnt_reg) begin
                    done_next = 1'b1;
                    st_next   = M_IDLE;
                end else begin
                    sel_next = sel_reg + 1'b1;
                    st_next  = M_RD;
                end
            end
            default: st_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= M_CLR;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            done_reg <= done_next;
        end
        sel_reg  <= sel_next;
        cnt_reg  <= cnt_next;
        chk_reg  <= chk_next;
        pres_reg <= pres_next;
    end

    assign sts.clearing = (st_reg == M_CLR);
    assign sts.done     = done_reg;
    assign sts.present  = pres_reg;
endmodule

### src/bloom_filter_add_check.sv
// Top level of the bloom filter add and membership check block
//
//  channel | direction | ports
//  --------+-----------+---------------------------------------------
//  s_      | in        | s_valid, s_ready, s_func, s_hash_0..s_hash_3
//  m_      | out       | m_valid, m_ready, m_present
//  cfg_    | in        | cfg_wr_en, cfg_index, cfg_data
//
// One item at a time: the modulo lanes find the remainders (one remainder bit per
// cycle, all lanes in parallel), a start strobe goes to the walk, then each applied
// hash takes a read and then a set or test on the single-port filter memory; the
// walk flags done and the result is loaded into the output register. A check
// stops at the first clear bit. The next item is taken once the result has
// moved into the output register.
// After reset a clearing pass zeroes all (VECTOR_CAPACITY+7)/8 bytes of the
// memory, one byte a cycle; no item is taken until it ends.
// The result register lets the next item enter while a result is stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bloom_filter_add_check import bfac_pkg::*; #(
    parameter int MAX_HASHES      = 4,
    parameter int VECTOR_CAPACITY = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VB_W-1:0]      cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [HASH_W-1:0]    s_hash_0,
    input  logic [HASH_W-1:0]    s_hash_1,
    input  logic [HASH_W-1:0]    s_hash_2,
    input  logic [HASH_W-1:0]    s_hash_3,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_present
);
    localparam int NUM_LANES = (MAX_HASHES < HASH_FIELDS) ? MAX_HASHES : HASH_FIELDS;
    localparam int LEN_W     = $clog2(VECTOR_CAPACITY + 1);
    localparam int IDX_W     = $clog2(VECTOR_CAPACITY);
    localparam int DEPTH     = (VECTOR_CAPACITY + 7) / 8;
    localparam int ADDR_W    = (IDX_W > 3) ? IDX_W - 3 : 1;

    localparam logic [1:0] ST_IDLE = 2'd0, ST_MOD = 2'd1, ST_WALK = 2'd2, ST_DONE = 2'd3;

    logic [VB_W-1:0]       vbits_reg;
    logic [HCNT_W-1:0]     nhash_reg;
    logic [1:0]            st_reg, st_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  chk_reg, chk_next;
    logic                  res_reg, res_next;
    logic                  start_reg, start_next;
    logic                  mv_reg, mv_next, mp_reg, mp_next;
    logic [LEN_W-1:0]      eff_len;
    logic [HCNT_W-1:0]     eff_n;
    logic [HASH_W-1:0]     hashes [HASH_FIELDS];
    logic [IDX_W-1:0]      idx [NUM_LANES];
    logic                  accept;
    bfac_cmd_t             cmd;
    bfac_sts_t             sts;

    // Config: zero or oversized length means full capacity; clamp hash count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg <= VB_W'(65536);
            nhash_reg <= HCNT_W'(4);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_VECTOR_BITS)   vbits_reg <= cfg_data;
            if (cfg_index == REG_HASHES_IN_USE) nhash_reg <= cfg_data[HCNT_W-1:0];
        end
    end

    always_comb begin
        if (vbits_reg == '0 || 32'(vbits_reg) > 32'(VECTOR_CAPACITY))
            eff_len = LEN_W'(VECTOR_CAPACITY);
        else
            eff_len = LEN_W'(vbits_reg);
        eff_n = (nhash_reg > HCNT_W'(NUM_LANES)) ? HCNT_W'(NUM_LANES) : nhash_reg;
    end

    assign hashes[0] = s_hash_0;
    assign hashes[1] = s_hash_1;
    assign hashes[2] = s_hash_2;
    assign hashes[3] = s_hash_3;

    assign s_ready = (st_reg == ST_IDLE) && !sts.clearing;
    assign accept  = s_valid && s_ready;

    // One modulo lane per hash field, up to MAX_HASHES
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bfac_mod_lane #(.LEN_W(LEN_W), .IDX_W(IDX_W)) u_lane (
            .aclk (aclk),
            .load (accept),
            .step (st_reg == ST_MOD),
            .len  (eff_len),
            .hash (hashes[g]),
            .rem  (idx[g])
        );
    end

    assign cmd.start    = start_reg;
    assign cmd.is_check = chk_reg;
    assign cmd.count    = eff_n;

    bfac_merge #(.NUM_LANES(NUM_LANES), .IDX_W(IDX_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .idx     (idx),
        .sts     (sts)
    );

    always_comb begin
        st_next    = st_reg;
        step_next  = step_reg;
        chk_next   = chk_reg;
        res_next   = res_reg;
        start_next = 1'b0;
        mv_next    = mv_reg && !m_ready;
        mp_next    = mp_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    chk_next  = s_func;
                    step_next = '0;
                    st_next   = ST_MOD;
                end
            end
            ST_MOD: begin
                // advance one remainder bit in every lane
                step_next = step_reg + 1'b1;
                if (step_reg == '1) begin
                    start_next = 1'b1;
                    st_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (sts.done) begin
                    res_next = sts.present;
                    st_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    mp_next = res_reg;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            start_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            start_reg <= start_next;
            mv_reg    <= mv_next;
        end
        step_reg <= step_next;
        chk_reg  <= chk_next;
        res_reg  <= res_next;
        mp_reg   <= mp_next;
    end

    assign m_valid   = mv_reg;
    assign m_present = mp_reg;

    `BFAC_ASSERT_NEVER(a_no_accept_in_clear, aclk, aresetn, s_ready && sts.clearing)
    `BFAC_ASSERT_NEXT(a_accept_starts_mod, aclk, aresetn, accept, st_reg == ST_MOD)
    `BFAC_ASSERT_IMPL(a_done_only_in_walk, aclk, aresetn, sts.done, st_reg == ST_WALK)
    `BFAC_ASSERT_IMPL(a_add_reports_one, aclk, aresetn, sts.done && !chk_reg, sts.present)
endmodule
